>>> rtl/sssp_pkg.sv
// ----------------------------------------------------------------------------
// sssp_pkg: shared types and constants for the shortest path engine
// Beat layouts of both channels, the edge store record and command codes.
// ----------------------------------------------------------------------------
package sssp_pkg;

  localparam int NODE_FIELD_W = 4;
  localparam int DIST_W       = 32;

  localparam logic [DIST_W-1:0] DIST_INF = '1;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_RUN   = 2'd2;

  typedef struct packed {
    logic [1:0]              command;
    logic [NODE_FIELD_W-1:0] edge_from;
    logic [NODE_FIELD_W-1:0] edge_to;
    logic [DIST_W-1:0]       edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [NODE_FIELD_W-1:0] node_index;
    logic [DIST_W-1:0]       distance;
    logic                    reachable;
    logic                    last;
    logic                    store_full;
  } out_item_t;

  typedef struct packed {
    logic [NODE_FIELD_W-1:0] from_node;
    logic [NODE_FIELD_W-1:0] to_node;
    logic [DIST_W-1:0]       cost;
  } edge_rec_t;

endpackage

>>> rtl/sssp_ram.sv
// ----------------------------------------------------------------------------
// sssp_ram: simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sssp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/single_source_shortest_paths.sv
// ----------------------------------------------------------------------------
// single_source_shortest_paths: Dijkstra engine over an edge store
// Loads directed weighted edges, then on a run beat computes the shortest
// distance from the configured source node by array scan, and reports one
// beat per node.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_item_t  (command, edge)
//   out      output     out_valid / out_stall  out_item_t (node result)
//   cfg      input      cfg_wr_en              cfg_wr_data (source node)
//
// An add beat yields one result beat. In a run, each round (one per settled
// node) scans the distance memory through its single read port and streams
// the edge store through a relaxation pipeline. Each report beat first issues
// the distance read and is loaded once the registered data is back and the
// output slot is free. No input beat is accepted from the run until the last
// report beat is loaded. Reset is synchronous and clears the edge count and
// source node.
// ----------------------------------------------------------------------------
module single_source_shortest_paths
  import sssp_pkg::*;
#(
  parameter int NODE_COUNT    = 16,
  parameter int EDGE_CAPACITY = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [NODE_FIELD_W-1:0] cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_item_t               out_data
);

  localparam int NW  = $clog2(NODE_COUNT);
  localparam int NCW = $clog2(NODE_COUNT + 1);
  localparam int EAW = $clog2(EDGE_CAPACITY > 1 ? EDGE_CAPACITY : 2);
  localparam int ECW = $clog2(EDGE_CAPACITY + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INIT   = 3'd1;
  localparam logic [2:0] S_SEL    = 3'd2;
  localparam logic [2:0] S_RELAX  = 3'd3;
  localparam logic [2:0] S_REPORT = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [NODE_FIELD_W-1:0] src_r;
  logic [ECW-1:0]          cnt_r, cnt_nxt;
  logic [NODE_COUNT-1:0]   dv_r, dv_nxt;
  logic [NODE_COUNT-1:0]   done_r, done_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_nxt;

  logic [NCW-1:0]    sel_idx_r, sel_idx_nxt;
  logic              pend_r, pend_nxt;
  logic [NW-1:0]     sel_node_r, sel_node_nxt;
  logic [DIST_W-1:0] best_r, best_nxt;
  logic [NW-1:0]     pick_r, pick_nxt;
  logic              found_r, found_nxt;

  logic [ECW-1:0]    e_r, e_nxt;
  logic              s1_v_r, s1_v_nxt;
  logic              s2_v_r, s2_v_nxt;
  logic [NW-1:0]     s2_to_r, s2_to_nxt;
  logic [DIST_W-1:0] s2_cand_r, s2_cand_nxt;
  logic              fwd_v_r, fwd_v_nxt;
  logic [NW-1:0]     fwd_addr_r, fwd_addr_nxt;
  logic [DIST_W-1:0] fwd_data_r, fwd_data_nxt;

  logic [NCW-1:0]    rep_idx_r, rep_idx_nxt;
  logic              primed_r, primed_nxt;

  logic              in_acc, slot_free, out_load, src_ok;
  logic              dist_wr_en, edge_wr_en;
  logic [NW-1:0]     dist_wr_addr, dist_rd_addr;
  logic [DIST_W-1:0] dist_wr_data, dist_q;
  edge_rec_t         edge_wr_data, edge_q;
  logic [EAW-1:0]    edge_wr_addr, edge_rd_addr;
  logic [DIST_W-1:0] cur, old;
  logic [DIST_W:0]   sum;

  sssp_ram #(.WIDTH(DIST_W), .DEPTH(NODE_COUNT)) u_dist_ram (
    .clk     (clk),
    .wr_en   (dist_wr_en),
    .wr_addr (dist_wr_addr),
    .wr_data (dist_wr_data),
    .rd_addr (dist_rd_addr),
    .rd_data (dist_q)
  );

  sssp_ram #(.WIDTH($bits(edge_rec_t)), .DEPTH(EDGE_CAPACITY)) u_edge_ram (
    .clk     (clk),
    .wr_en   (edge_wr_en),
    .wr_addr (edge_wr_addr),
    .wr_data (edge_wr_data),
    .rd_addr (edge_rd_addr),
    .rd_data (edge_q)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign src_ok    = 32'(src_r) < 32'(NODE_COUNT);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign edge_wr_addr = EAW'(cnt_r);
  assign edge_rd_addr = EAW'(e_r);
  assign edge_wr_data = '{from_node: in_data.edge_from, to_node: in_data.edge_to,
                          cost: in_data.edge_weight};

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    dv_nxt       = dv_r;
    done_nxt     = done_r;
    out_nxt      = out_data_r;
    out_load     = 1'b0;
    sel_idx_nxt  = sel_idx_r;
    pend_nxt     = pend_r;
    sel_node_nxt = sel_node_r;
    best_nxt     = best_r;
    pick_nxt     = pick_r;
    found_nxt    = found_r;
    e_nxt        = e_r;
    s1_v_nxt     = 1'b0;
    s2_v_nxt     = 1'b0;
    s2_to_nxt    = s2_to_r;
    s2_cand_nxt  = s2_cand_r;
    fwd_v_nxt    = 1'b0;
    fwd_addr_nxt = fwd_addr_r;
    fwd_data_nxt = fwd_data_r;
    rep_idx_nxt  = rep_idx_r;
    primed_nxt   = primed_r;
    dist_wr_en   = 1'b0;
    dist_wr_addr = '0;
    dist_wr_data = '0;
    dist_rd_addr = '0;
    edge_wr_en   = 1'b0;
    cur          = DIST_INF;
    old          = DIST_INF;
    sum          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.command)
            CMD_CLEAR: cnt_nxt = '0;
            CMD_ADD: begin
              out_load = 1'b1;
              out_nxt  = '0;
              if (cnt_r < ECW'(EDGE_CAPACITY)) begin
                edge_wr_en = 1'b1;
                cnt_nxt    = cnt_r + 1'b1;
              end else begin
                out_nxt.store_full = 1'b1;
              end
            end
            CMD_RUN: state_nxt = S_INIT;
            default: ;
          endcase
        end
      end

      S_INIT: begin
        // An entry without its valid bit reads as unreached.
        dv_nxt   = '0;
        done_nxt = '0;
        if (src_ok) begin
          dist_wr_en             = 1'b1;
          dist_wr_addr           = NW'(src_r);
          dist_wr_data           = '0;
          dv_nxt[NW'(src_r)]     = 1'b1;
        end
        state_nxt   = S_SEL;
        sel_idx_nxt = '0;
        pend_nxt    = 1'b0;
        best_nxt    = DIST_INF;
        found_nxt   = 1'b0;
      end

      S_SEL: begin
        dist_rd_addr = NW'(sel_idx_r);
        if (sel_idx_r < NCW'(NODE_COUNT)) begin
          sel_idx_nxt  = sel_idx_r + 1'b1;
          pend_nxt     = 1'b1;
          sel_node_nxt = NW'(sel_idx_r);
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          cur = dv_r[sel_node_r] ? dist_q : DIST_INF;
          // Strict compare keeps the lowest index on a tie.
          if (!done_r[sel_node_r] && cur < best_r) begin
            best_nxt  = cur;
            pick_nxt  = sel_node_r;
            found_nxt = 1'b1;
          end
        end
        if (sel_idx_r == NCW'(NODE_COUNT) && !pend_r) begin
          if (found_r) begin
            state_nxt = S_RELAX;
            e_nxt     = '0;
          end else begin
            state_nxt   = S_REPORT;
            rep_idx_nxt = '0;
            primed_nxt  = 1'b0;
          end
        end
      end

      S_RELAX: begin
        if (e_r < cnt_r) begin
          e_nxt    = e_r + 1'b1;
          s1_v_nxt = 1'b1;
        end
        // Stage one: edge record is back, fetch the end node's distance.
        dist_rd_addr = NW'(edge_q.to_node);
        s2_v_nxt     = s1_v_r && (32'(edge_q.from_node) == 32'(pick_r)) &&
                       (32'(edge_q.to_node) < 32'(NODE_COUNT));
        s2_to_nxt    = NW'(edge_q.to_node);
        sum          = {1'b0, best_r} + {1'b0, edge_q.cost};
        s2_cand_nxt  = sum[DIST_W] ? DIST_INF : sum[DIST_W-1:0];
        // Stage two: the memory read misses a write made while it was issued,
        // so that write is forwarded.
        if (s2_v_r) begin
          if (fwd_v_r && fwd_addr_r == s2_to_r) begin
            old = fwd_data_r;
          end else begin
            old = dv_r[s2_to_r] ? dist_q : DIST_INF;
          end
          if (s2_cand_r < old) begin
            dist_wr_en      = 1'b1;
            dist_wr_addr    = s2_to_r;
            dist_wr_data    = s2_cand_r;
            dv_nxt[s2_to_r] = 1'b1;
            fwd_v_nxt       = 1'b1;
            fwd_addr_nxt    = s2_to_r;
            fwd_data_nxt    = s2_cand_r;
          end
        end
        if (e_r == cnt_r && !s1_v_r && !s2_v_r) begin
          done_nxt[pick_r] = 1'b1;
          state_nxt        = S_SEL;
          sel_idx_nxt      = '0;
          pend_nxt         = 1'b0;
          best_nxt         = DIST_INF;
          found_nxt        = 1'b0;
        end
      end

      S_REPORT: begin
        dist_rd_addr = NW'(rep_idx_r);
        if (!primed_r) begin
          primed_nxt = 1'b1;
        end else if (slot_free) begin
          cur                = dv_r[NW'(rep_idx_r)] ? dist_q : DIST_INF;
          out_load           = 1'b1;
          out_nxt.node_index = NODE_FIELD_W'(rep_idx_r);
          out_nxt.distance   = cur;
          out_nxt.reachable  = cur != DIST_INF;
          out_nxt.last       = rep_idx_r == NCW'(NODE_COUNT - 1);
          out_nxt.store_full = 1'b0;
          rep_idx_nxt        = rep_idx_r + 1'b1;
          primed_nxt         = 1'b0;
          if (rep_idx_r == NCW'(NODE_COUNT - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      src_r       <= '0;
      cnt_r       <= '0;
      dv_r        <= '0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      fwd_v_r     <= 1'b0;
      primed_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        src_r <= cfg_wr_data;
      end
      cnt_r       <= cnt_nxt;
      dv_r        <= dv_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      fwd_v_r     <= fwd_v_nxt;
      primed_r    <= primed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
    sel_idx_r  <= sel_idx_nxt;
    sel_node_r <= sel_node_nxt;
    best_r     <= best_nxt;
    pick_r     <= pick_nxt;
    e_r        <= e_nxt;
    s2_to_r    <= s2_to_nxt;
    s2_cand_r  <= s2_cand_nxt;
    fwd_addr_r <= fwd_addr_nxt;
    fwd_data_r <= fwd_data_nxt;
    rep_idx_r  <= rep_idx_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ECW'(EDGE_CAPACITY))
    else $error("edge count beyond capacity");

  a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_RELAX) |-> (!s1_v_r && !s2_v_r))
    else $error("relaxation pipeline busy outside relaxation");

  a_pick_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RELAX) |-> (dv_r[pick_r] && !done_r[pick_r]))
    else $error("relaxing from an unreached or settled node");

  a_relax_finite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RELAX && dist_wr_en) |-> (dist_wr_data != DIST_INF))
    else $error("relaxation wrote an infinite distance");

  a_report_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REPORT && out_load && out_nxt.last) |=> (state_r == S_IDLE))
    else $error("report did not end after the last beat");

endmodule
